// File: src/batch_latency_predictor_core_macros.svh
// assertion helpers for the batch latency predictor
// each expects clk and arst_n in scope
`ifndef BATCH_LATENCY_PREDICTOR_CORE_MACROS_SVH
`define BATCH_LATENCY_PREDICTOR_CORE_MACROS_SVH

// consequent checked in the same cycle
`define BLP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define BLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types, request codes and helpers of the batch latency predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package blp_pkg;

	localparam int SIZE_CAP_DEF = 256;

	localparam logic [1:0] REQ_ENQUEUE    = 2'd0;
	localparam logic [1:0] REQ_COMPLETE   = 2'd1;
	localparam logic [1:0] REQ_START_IDLE = 2'd2;
	localparam logic [1:0] REQ_QUERY      = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_E_RD,
		ST_E_MUL,
		ST_E_FIN,
		ST_Q_RD_A,
		ST_Q_MUL_A,
		ST_Q_RD_B,
		ST_Q_MUL_B,
		ST_Q_FIN,
		ST_C_RD,
		ST_C_TAB,
		ST_C_DIV,
		ST_C_WR,
		ST_STI,
		ST_ZERO_FIN
	} state_t;

	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_ENQ,
		OUT_QRY
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     clr_wr;
		logic     rd_a;
		logic     rd_b;
		logic     cap_a;
		logic     cost_a;
		logic     cap_b;
		logic     enq_upd;
		logic     cmp_upd;
		logic     sti_upd;
		logic     tab_wr;
		logic     load_out;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic learn;
		logic div_busy;
	} sts_t;

	// (d * 3) / 4 with the product kept in 34 bits, bits 33:2 returned
	function automatic logic [31:0] three_quarter(input logic [31:0] d);
		logic [33:0] t;
		t = {2'b00, d} + {1'b0, d, 1'b0};
		return t[33:2];
	endfunction

endpackage

`default_nettype wire

// File: src/blp_ram.sv
// ----------------------------------------------------------------------------
// blp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 257
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/blp_div.sv
// ----------------------------------------------------------------------------
// blp_div
// Shift-subtract divider: 32-bit dividend by a narrow divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_div #(
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   dividend,
	input  wire logic [DW-1:0] divisor,
	output      logic          busy,
	output      logic [31:0]   quotient
);

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic          busy_q;
	logic [4:0]    cnt_q;
	logic [31:0]   quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   trial_c;
	logic [DW:0]   diff_c;
	logic          ge_c;

	always_comb begin
		trial_c = {rem_q, quo_q[31]};
		diff_c  = trial_c - {1'b0, div_q};
		ge_c    = trial_c >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], ge_c};
			rem_q <= ge_c ? diff_c[DW-1:0] : trial_c[DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: src/blp_ctrl.sv
// ----------------------------------------------------------------------------
// blp_ctrl
// Sequencer of the batch latency predictor: clearing pass, request decode
// and the step-by-step commands for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_ctrl import blp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  wire sts_t       sts,
	output      cmd_t       cmd,
	output      logic       busy,
	output      logic       done
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.load_out;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_ENQUEUE:    state_d = ST_E_RD;
						REQ_COMPLETE:   state_d = ST_C_RD;
						REQ_START_IDLE: state_d = ST_STI;
						REQ_QUERY:      state_d = ST_Q_RD_A;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_E_RD:    state_d = ST_E_MUL;
			ST_E_MUL:   state_d = ST_E_FIN;
			ST_E_FIN:   state_d = ST_IDLE;
			ST_Q_RD_A:  state_d = ST_Q_MUL_A;
			ST_Q_MUL_A: state_d = ST_Q_RD_B;
			ST_Q_RD_B:  state_d = ST_Q_MUL_B;
			ST_Q_MUL_B: state_d = ST_Q_FIN;
			ST_Q_FIN:   state_d = ST_IDLE;
			ST_C_RD: begin
				// negative measured time or size zero learns nothing
				state_d = sts.learn ? ST_C_TAB : ST_ZERO_FIN;
			end
			ST_C_TAB:   state_d = ST_C_DIV;
			ST_C_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_C_WR;
				end
			end
			ST_C_WR:     state_d = ST_IDLE;
			ST_STI:      state_d = ST_IDLE;
			ST_ZERO_FIN: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.out_sel = OUT_ZERO;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.capture = start;
			ST_E_RD:  cmd.rd_a = 1'b1;
			ST_E_MUL: cmd.cap_a = 1'b1;
			ST_E_FIN: begin
				cmd.enq_upd  = 1'b1;
				cmd.load_out = 1'b1;
				cmd.out_sel  = OUT_ENQ;
			end
			ST_Q_RD_A:  cmd.rd_a = 1'b1;
			ST_Q_MUL_A: cmd.cap_a = 1'b1;
			ST_Q_RD_B: begin
				cmd.rd_b   = 1'b1;
				cmd.cost_a = 1'b1;
			end
			ST_Q_MUL_B: cmd.cap_b = 1'b1;
			ST_Q_FIN: begin
				cmd.load_out = 1'b1;
				cmd.out_sel  = OUT_QRY;
			end
			ST_C_RD: begin
				cmd.rd_a    = 1'b1;
				cmd.cmp_upd = 1'b1;
			end
			ST_C_TAB: cmd.cap_b = 1'b1;
			ST_C_DIV: cmd.cap_b = 1'b0;
			ST_C_WR: begin
				cmd.tab_wr   = 1'b1;
				cmd.load_out = 1'b1;
			end
			ST_STI: begin
				cmd.sti_upd  = 1'b1;
				cmd.load_out = 1'b1;
			end
			ST_ZERO_FIN: cmd.load_out = 1'b1;
			default:     cmd.load_out = 1'b0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

endmodule

`default_nettype wire

// File: src/blp_dp.sv
// ----------------------------------------------------------------------------
// blp_dp
// Datapath: request registers, time and queue state, learned-time table,
// cost multiplier, divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_dp import blp_pkg::*; #(
	parameter int SIZE_CAP = SIZE_CAP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [8:0]  job_size,
	input  wire logic [8:0]  second_job_size,
	input  wire logic [62:0] now_ns,
	input  wire logic [31:0] given_prediction,
	input  wire logic [30:0] given_original,
	input  wire cmd_t        cmd,
	output      sts_t        sts,
	output      logic [31:0] predicted_time,
	output      logic [30:0] original_time,
	output      logic        engine_was_idle,
	output      logic [31:0] second_cost,
	output      logic [31:0] idle_wait_ns
);

	localparam int DEPTH = SIZE_CAP + 1;
	localparam int SW    = $clog2(DEPTH);
	localparam logic [SW-1:0] SMAX = SW'(SIZE_CAP);

	function automatic logic [SW-1:0] clamp_size(input logic [8:0] s);
		logic [31:0] w;
		w = 32'(s);
		if (w > 32'(SIZE_CAP)) begin
			return SMAX;
		end
		return w[SW-1:0];
	endfunction

	// request
	logic [SW-1:0] s_q;
	logic [SW-1:0] s2_q;
	logic [62:0]   now_q;
	logic [31:0]   pred_q;
	logic [30:0]   orig_q;

	// architectural state
	logic [63:0]   last_q;
	logic [63:0]   queued_q;
	logic [31:0]   entry0_q;
	logic [SW-1:0] clr_cnt_q;

	// working registers
	logic [31:0]   tab_q;
	logic [31:0]   mul_q;
	logic [31:0]   cost_a_q;
	logic [31:0]   meas_q;
	logic [63:0]   w1_q;
	logic [63:0]   w_q;

	// result registers
	logic [31:0]   pred_out_q;
	logic [30:0]   orig_out_q;
	logic          idle_out_q;
	logic [31:0]   cost2_out_q;
	logic [31:0]   wait_out_q;

	logic [63:0]      now64_c;
	logic [63:0]      dlt_c;
	logic [31:0]      meas_c;
	logic             learn_c;
	logic [SW-1:0]    s_mul_c;
	logic [31+SW:0]   prod_c;
	logic [31:0]      cost_c;
	logic [31:0]      o_c;
	logic [31:0]      new_tab_c;
	logic [31:0]      new_e0_c;
	logic [31:0]      wait_c;
	logic [31:0]      quot;
	logic             div_busy;
	logic             div_start;
	logic             ram_we;
	logic [SW-1:0]    ram_waddr;
	logic [31:0]      ram_wdata;
	logic [SW-1:0]    ram_raddr;
	logic [31:0]      ram_rdata;

	always_comb begin
		now64_c  = {1'b0, now_q};
		dlt_c    = now64_c - last_q;
		meas_c   = dlt_c[31:0];
		learn_c  = !meas_c[31] && (s_q != '0);
		s_mul_c  = cmd.cap_b ? s2_q : s_q;
		prod_c   = entry0_q * s_mul_c;
		cost_c   = (tab_q != '0) ? tab_q : mul_q;
		// a zero original falls back to the stored entry
		o_c      = (orig_q == '0) ? tab_q : {1'b0, orig_q};
		if ((orig_q == '0) && (tab_q == '0)) begin
			new_tab_c = meas_q;
		end else begin
			new_tab_c = tab_q + three_quarter(meas_q - o_c);
		end
		if (entry0_q == '0) begin
			new_e0_c = quot;
		end else begin
			new_e0_c = entry0_q + three_quarter(quot - entry0_q);
		end
		wait_c = ((queued_q == '0) || w_q[63]) ? 32'd0 : w_q[31:0];
	end

	assign div_start = cmd.cmp_upd && learn_c;

	blp_div #(
		.DW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (meas_c),
		.divisor  (s_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	// clearing pass writes zero, learning writes the new entry
	assign ram_we    = cmd.clr_wr || cmd.tab_wr;
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : s_q;
	assign ram_wdata = cmd.clr_wr ? 32'd0 : new_tab_c;
	assign ram_raddr = cmd.rd_b ? s2_q : s_q;

	blp_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_a || cmd.rd_b),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			queued_q  <= '0;
			entry0_q  <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + SW'(1);
			end
			if (cmd.enq_upd) begin
				if (queued_q == '0) begin
					last_q <= now64_c;
				end
				queued_q <= queued_q + {32'd0, cost_c};
			end
			if (cmd.cmp_upd) begin
				last_q   <= now64_c;
				queued_q <= queued_q - {32'd0, pred_q};
			end
			if (cmd.sti_upd) begin
				last_q <= now64_c;
			end
			if (cmd.tab_wr) begin
				entry0_q <= new_e0_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q    <= clamp_size(job_size);
			s2_q   <= clamp_size(second_job_size);
			now_q  <= now_ns;
			pred_q <= given_prediction;
			orig_q <= given_original;
		end
		if (cmd.cap_a) begin
			// entry 0 lives in a register, not in the table
			tab_q <= (s_q == '0) ? entry0_q : ram_rdata;
			mul_q <= prod_c[31:0];
		end
		if (cmd.cap_b) begin
			tab_q <= ram_rdata;
			mul_q <= prod_c[31:0];
			w_q   <= w1_q + queued_q;
		end
		if (cmd.cost_a) begin
			cost_a_q <= cost_c;
			w1_q     <= last_q - now64_c;
		end
		if (cmd.cmp_upd) begin
			meas_q <= meas_c;
		end
		if (cmd.load_out) begin
			unique case (cmd.out_sel)
				OUT_ENQ: begin
					pred_out_q  <= cost_c;
					orig_out_q  <= tab_q[30:0];
					idle_out_q  <= queued_q == '0;
					cost2_out_q <= '0;
					wait_out_q  <= '0;
				end
				OUT_QRY: begin
					pred_out_q  <= cost_a_q;
					orig_out_q  <= '0;
					idle_out_q  <= 1'b0;
					cost2_out_q <= (s2_q == '0) ? 32'd0 : cost_c;
					wait_out_q  <= wait_c;
				end
				default: begin
					pred_out_q  <= '0;
					orig_out_q  <= '0;
					idle_out_q  <= 1'b0;
					cost2_out_q <= '0;
					wait_out_q  <= '0;
				end
			endcase
		end
	end

	always_comb begin
		sts.clr_last = clr_cnt_q == SMAX;
		sts.learn    = learn_c;
		sts.div_busy = div_busy;
	end

	assign predicted_time  = pred_out_q;
	assign original_time   = orig_out_q;
	assign engine_was_idle = idle_out_q;
	assign second_cost     = cost2_out_q;
	assign idle_wait_ns    = wait_out_q;

endmodule

`default_nettype wire

// File: src/batch_latency_predictor_core.sv
// ----------------------------------------------------------------------------
// batch_latency_predictor_core
// Learns per-size batch run times of one compute engine and predicts batch
// cost and time until the engine goes idle.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; req_type selects
//   enqueue, complete, start when idle or query. Every request gives exactly
//   one result, shown for one cycle with done high; the receiver must take it
//   then, it cannot stall the block.
//   One request at a time: busy stays high from the transfer until the cycle
//   done rises, and a new request may be transferred in that same cycle.
//   A complete that learns waits on the 32-step shift-subtract divider that
//   forms the per-item average; a complete that learns nothing skips it.
//   After reset the learned-time table is cleared one entry per cycle, all
//   SIZE_CAP+1 entries, with busy high; time and queue state reset at once.
//   Outputs a request kind does not define read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_latency_predictor_core import blp_pkg::*; #(
	parameter int SIZE_CAP = SIZE_CAP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [8:0]  job_size,
	input  wire logic [8:0]  second_job_size,
	input  wire logic [62:0] now_ns,
	input  wire logic [31:0] given_prediction,
	input  wire logic [30:0] given_original,
	output      logic        done,
	output      logic [31:0] predicted_time,
	output      logic [30:0] original_time,
	output      logic        engine_was_idle,
	output      logic [31:0] second_cost,
	output      logic [31:0] idle_wait_ns
);

	cmd_t cmd;
	sts_t sts;

	blp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	blp_dp #(
		.SIZE_CAP(SIZE_CAP)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_size          (job_size),
		.second_job_size   (second_job_size),
		.now_ns            (now_ns),
		.given_prediction  (given_prediction),
		.given_original    (given_original),
		.cmd               (cmd),
		.sts               (sts),
		.predicted_time    (predicted_time),
		.original_time     (original_time),
		.engine_was_idle   (engine_was_idle),
		.second_cost       (second_cost),
		.idle_wait_ns      (idle_wait_ns)
	);

endmodule

`default_nettype wire

// File: src/blp_checker.sv
// ----------------------------------------------------------------------------
// blp_checker
// Port-level checks of the request and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "batch_latency_predictor_core_macros.svh"

module blp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// a transfer always starts work, so busy rises after it
	`BLP_ASSERT_NEXT(a_busy_after_xfer, start && !busy, busy, "busy low after a request transfer")

	// a result appears only as the block returns to idle
	`BLP_ASSERT_SAME(a_done_not_busy, done, !busy, "done while busy")

	// one result per request, never two in a row
	`BLP_ASSERT_NEXT(a_done_single, done, !done, "done held for two cycles")

	// no result in the cycle right after a transfer
	`BLP_ASSERT_NEXT(a_no_early_done, start && !busy, !done, "result right after transfer")

endmodule

bind batch_latency_predictor_core blp_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends enqueue, complete, start-when-idle and query requests to the batch
// latency predictor and checks every result field against a local model of
// the learned-time table, the last completion time and the queued work.
// Completes mostly hand back what their enqueue returned, with noise mixed in.
// ----------------------------------------------------------------------------
module testbench;
	import blp_pkg::*;

	localparam int NUM_RANDOM  = 1600;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_PRINTED = 30;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  size;
		logic [8:0]  size2;
		logic [62:0] now;
		logic [31:0] pred;
		logic [30:0] orig;
		logic        track;
		logic        from_enq;
		int          gap_pct;
	} request_t;

	typedef struct packed {
		logic [31:0] cost;
		logic [30:0] orig;
		logic        was_idle;
		logic [31:0] cost2;
		logic [31:0] wait_ns;
	} outcome_t;

	// what an enqueue returned, handed back by the matching complete
	typedef struct packed {
		logic [8:0]  size;
		logic [31:0] pred;
		logic [30:0] orig;
	} ticket_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_ENQUEUE;
	logic [8:0]  job_size = '0;
	logic [8:0]  second_job_size = '0;
	logic [62:0] now_ns = '0;
	logic [31:0] given_prediction = '0;
	logic [30:0] given_original = '0;
	logic        busy;
	logic        done;
	logic [31:0] predicted_time;
	logic [30:0] original_time;
	logic        engine_was_idle;
	logic [31:0] second_cost;
	logic [31:0] idle_wait_ns;

	batch_latency_predictor_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.req_type          (req_type),
		.job_size          (job_size),
		.second_job_size   (second_job_size),
		.now_ns            (now_ns),
		.given_prediction  (given_prediction),
		.given_original    (given_original),
		.done              (done),
		.predicted_time    (predicted_time),
		.original_time     (original_time),
		.engine_was_idle   (engine_was_idle),
		.second_cost       (second_cost),
		.idle_wait_ns      (idle_wait_ns)
	);

	logic [31:0] learned_ns [0:SIZE_CAP_DEF];
	logic [63:0] last_done_ns;
	logic [63:0] queued_ns;

	request_t pending_q[$];
	outcome_t expected_q[$];
	ticket_t  ticket_q[$];
	request_t cur_req;
	int       xfer_count = 0;
	int       issued_count = 0;
	int       err_count = 0;
	int       items_made = 0;
	int       gap_pct = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [8:0] clip_size(input logic [8:0] s);
		return (s > 9'(SIZE_CAP_DEF)) ? 9'(SIZE_CAP_DEF) : s;
	endfunction

	function automatic logic [31:0] cost_of(input logic [8:0] s);
		return (learned_ns[s] != 32'd0) ? learned_ns[s] : learned_ns[0] * {23'd0, s};
	endfunction

	function automatic logic [31:0] scale_3_4(input logic [31:0] d);
		logic [63:0] p;
		p = ({32'd0, d} * 64'd3) / 64'd4;
		return p[31:0];
	endfunction

	function automatic outcome_t predict_request(input request_t r);
		outcome_t    o;
		ticket_t     tk;
		logic [8:0]  s;
		logic [8:0]  s2;
		logic [31:0] meas;
		logic [31:0] per_item;
		logic [31:0] base;
		logic [63:0] w;
		logic        seeded;
		o = '0;
		s = clip_size(r.size);
		s2 = clip_size(r.size2);
		case (r.kind)
		REQ_ENQUEUE: begin
			o.cost = cost_of(s);
			o.orig = learned_ns[s][30:0];
			o.was_idle = (queued_ns == 64'd0);
			if (o.was_idle)
				last_done_ns = {1'b0, r.now};
			queued_ns = queued_ns + {32'd0, o.cost};
			if (r.track) begin
				tk.size = r.size;
				tk.pred = o.cost;
				tk.orig = o.orig;
				ticket_q.insert(ticket_q.size(), tk);
			end
		end
		REQ_COMPLETE: begin
			w = {1'b0, r.now} - last_done_ns;
			meas = w[31:0];
			last_done_ns = {1'b0, r.now};
			queued_ns = queued_ns - {32'd0, r.pred};
			// negative measured time or size zero learns nothing
			if (!meas[31] && s != 9'd0) begin
				per_item = meas / {23'd0, s};
				base = {1'b0, r.orig};
				seeded = 1'b0;
				if (base == 32'd0) begin
					if (learned_ns[s] == 32'd0) begin
						learned_ns[s] = meas;
						seeded = 1'b1;
					end else begin
						base = learned_ns[s];
					end
				end
				if (!seeded)
					learned_ns[s] = learned_ns[s] + scale_3_4(meas - base);
				if (learned_ns[0] == 32'd0)
					learned_ns[0] = per_item;
				else
					learned_ns[0] = learned_ns[0] + scale_3_4(per_item - learned_ns[0]);
			end
		end
		REQ_START_IDLE: begin
			last_done_ns = {1'b0, r.now};
		end
		REQ_QUERY: begin
			o.cost = cost_of(s);
			o.cost2 = (s2 != 9'd0) ? cost_of(s2) : 32'd0;
			if (queued_ns != 64'd0) begin
				w = last_done_ns - {1'b0, r.now} + queued_ns;
				o.wait_ns = w[63] ? 32'd0 : w[31:0];
			end
		end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (err_count < MAX_PRINTED)
			$display("%0t ns: %s got %h expected %h", $time, what, got, want);
		err_count++;
	endtask

	task automatic add_req(input logic [1:0] kind, input logic [8:0] size,
		input logic [8:0] size2, input logic [62:0] now, input logic [31:0] pred,
		input logic [30:0] orig, input logic track, input logic from_enq);
		request_t r;
		r.kind = kind;
		r.size = size;
		r.size2 = size2;
		r.now = now;
		r.pred = pred;
		r.orig = orig;
		r.track = track;
		r.from_enq = from_enq;
		r.gap_pct = gap_pct;
		pending_q.insert(pending_q.size(), r);
		items_made++;
	endtask

	function automatic logic [8:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return 9'($urandom_range(1, 8));
		if (roll < 90)
			return 9'($urandom_range(1, SIZE_CAP_DEF));
		if (roll < 95)
			return 9'($urandom_range(SIZE_CAP_DEF + 1, 511));
		return 9'd0;
	endfunction

	task automatic add_query(input logic [62:0] now);
		add_req(REQ_QUERY, pick_size(), ($urandom_range(3) == 0) ? 9'd0 : pick_size(),
			now, '0, '0, 1'b0, 1'b0);
	endtask

	// driver: a new request goes out once the previous one has been transferred
	always @(negedge clk) begin : driver
		request_t nxt;
		ticket_t  tk;
		if (arst_n && xfer_count == issued_count) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].gap_pct) begin
				nxt = pending_q.pop_front();
				if (nxt.from_enq && ticket_q.size() != 0) begin
					tk = ticket_q.pop_front();
					nxt.size = tk.size;
					nxt.pred = tk.pred;
					nxt.orig = tk.orig;
				end
				cur_req = nxt;
				req_type <= nxt.kind;
				job_size <= nxt.size;
				second_job_size <= nxt.size2;
				now_ns <= nxt.now;
				given_prediction <= nxt.pred;
				given_original <= nxt.orig;
				start <= 1'b1;
				issued_count++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, then predict the request transferred at this edge
	always @(posedge clk) begin : monitor
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing pending", 32'd0, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (predicted_time !== want.cost)
						report_mismatch("predicted_time", predicted_time, want.cost);
					if (original_time !== want.orig)
						report_mismatch("original_time", {1'b0, original_time}, {1'b0, want.orig});
					if (engine_was_idle !== want.was_idle)
						report_mismatch("engine_was_idle", {31'd0, engine_was_idle},
							{31'd0, want.was_idle});
					if (second_cost !== want.cost2)
						report_mismatch("second_cost", second_cost, want.cost2);
					if (idle_wait_ns !== want.wait_ns)
						report_mismatch("idle_wait_ns", idle_wait_ns, want.wait_ns);
				end
			end
			if (start && !busy) begin
				expected_q.insert(expected_q.size(), predict_request(cur_req));
				xfer_count++;
			end
		end
	end

	initial begin : stimulus
		logic [62:0] t_now;
		logic [63:0] junk_now;
		logic [31:0] junk_pred;
		logic [1:0]  junk_kind;
		logic [8:0]  sizes [0:3];
		int          rand_base;
		int          phase;
		int          roll;
		int          burst;
		bit          jumped;
		for (int i = 0; i <= SIZE_CAP_DEF; i++)
			learned_ns[i] = 32'd0;
		last_done_ns = 64'd0;
		queued_ns = 64'd0;
		jumped = 1'b0;

		// directed requests
		add_req(REQ_QUERY, 9'd0, 9'd0, 63'd0, '0, '0, 1'b0, 1'b0);
		add_req(REQ_ENQUEUE, 9'd1, 9'd0, 63'd100, '0, '0, 1'b1, 1'b0);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'd1100, '0, '0, 1'b0, 1'b1);
		add_req(REQ_ENQUEUE, 9'd256, 9'd0, 63'd1200, '0, '0, 1'b1, 1'b0);
		add_req(REQ_ENQUEUE, 9'd511, 9'd0, 63'd1300, '0, '0, 1'b1, 1'b0);
		add_req(REQ_QUERY, 9'd1, 9'd511, 63'd1500, '0, '0, 1'b0, 1'b0);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'd300000, '0, '0, 1'b0, 1'b1);
		// zero original with a learned entry falls back to the entry
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'd560000, '0, '0, 1'b0, 1'b1);
		add_req(REQ_ENQUEUE, 9'd1, 9'd0, 63'd600000, '0, '0, 1'b1, 1'b0);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'd600900, '0, '0, 1'b0, 1'b1);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'd601000, '0, '0, 1'b0, 1'b0);
		add_req(REQ_START_IDLE, 9'd0, 9'd0, 63'd700000, '0, '0, 1'b0, 1'b0);
		// time going backward gives a negative measured time
		add_req(REQ_COMPLETE, 9'd5, 9'd0, 63'd600000, '0, '0, 1'b0, 1'b0);
		add_req(REQ_ENQUEUE, 9'd2, 9'd0, 63'd700100, '0, '0, 1'b1, 1'b0);
		add_req(REQ_QUERY, 9'd2, 9'd1, '1, '0, '0, 1'b0, 1'b0);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, '1, '0, '0, 1'b0, 1'b1);
		add_req(REQ_COMPLETE, 9'd3, 9'd0, 63'd0, '0, '1, 1'b0, 1'b0);
		// drive entry 9 to all ones, then drain a full-scale prediction with it
		add_req(REQ_COMPLETE, 9'd9, 9'd0, 63'h4000_0002, '0, '0, 1'b0, 1'b0);
		add_req(REQ_COMPLETE, 9'd9, 9'd0, 63'h4000_0002, '0, 31'd4, 1'b0, 1'b0);
		add_req(REQ_COMPLETE, 9'd0, 9'd0, 63'h4000_0002, '1, '1, 1'b0, 1'b0);
		add_req(REQ_ENQUEUE, 9'd9, 9'd0, 63'h4000_0003, '0, '0, 1'b0, 1'b0);
		add_req(REQ_QUERY, 9'd9, 9'd0, 63'h4000_0004, '0, '0, 1'b0, 1'b0);
		add_req(REQ_QUERY, 9'd256, 9'd256, 63'h4000_0005, '0, '0, 1'b0, 1'b0);

		t_now = 63'd1000000;
		add_req(REQ_START_IDLE, 9'd0, 9'd0, t_now, '0, '0, 1'b0, 1'b0);

		rand_base = items_made;
		while (items_made - rand_base < NUM_RANDOM) begin
			phase = (items_made - rand_base) * 4 / NUM_RANDOM;
			gap_pct = (phase == 1) ? 50 : (phase == 3) ? 37 : 0;
			if (phase == 3 && !jumped) begin
				// move the clock up so the high time bits are exercised too
				jumped = 1'b1;
				t_now = 63'h3FFF_FFFF_0000_0000;
				add_req(REQ_START_IDLE, 9'd0, 9'd0, t_now, '0, '0, 1'b0, 1'b0);
			end
			roll = $urandom_range(99);
			if (roll < 75) begin
				burst = $urandom_range(1, 4);
				for (int j = 0; j < burst; j++) begin
					sizes[j] = pick_size();
					t_now = t_now + 63'($urandom_range(0, 300));
					add_req(REQ_ENQUEUE, sizes[j], 9'd0, t_now, '0, '0, 1'b1, 1'b0);
					if ($urandom_range(3) == 0)
						add_query(t_now);
				end
				for (int j = 0; j < burst; j++) begin
					t_now = t_now + 63'(clip_size(sizes[j]) * $urandom_range(20, 60))
						+ 63'($urandom_range(0, 500));
					add_req(REQ_COMPLETE, 9'd0, 9'd0, t_now, '0, '0, 1'b0, 1'b1);
					if ($urandom_range(3) == 0)
						add_query(t_now);
				end
			end else if (roll < 90) begin
				junk_now = {$urandom, $urandom};
				junk_pred = $urandom;
				junk_kind = 2'($urandom_range(3));
				t_now = t_now + 63'($urandom_range(0, 1000));
				add_req(junk_kind, 9'($urandom_range(511)), 9'($urandom_range(511)),
					junk_now[62:0], junk_pred, 31'($urandom), junk_kind == REQ_ENQUEUE, 1'b0);
				// undo the effect on queued work and bring the time base back
				if (junk_kind == REQ_ENQUEUE)
					add_req(REQ_COMPLETE, 9'd0, 9'd0, t_now, '0, '0, 1'b0, 1'b1);
				else if (junk_kind == REQ_COMPLETE)
					add_req(REQ_COMPLETE, 9'd0, 9'd0, t_now, -junk_pred, '0, 1'b0, 1'b0);
				else
					add_req(REQ_START_IDLE, 9'd0, 9'd0, t_now, '0, '0, 1'b0, 1'b0);
			end else begin
				// complete with no matching enqueue and a made-up original
				t_now = t_now + 63'($urandom_range(0, 2000));
				add_req(REQ_COMPLETE, pick_size(), 9'd0, t_now, '0, 31'($urandom_range(0, 100000)),
					1'b0, 1'b0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || xfer_count != issued_count)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("batch_latency_predictor_core verification clean");
		end else begin
			$display("batch_latency_predictor_core verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("batch_latency_predictor_core verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/blp_pkg.sv
src/blp_ram.sv
src/blp_div.sv
src/blp_ctrl.sv
src/blp_dp.sv
src/batch_latency_predictor_core.sv
src/blp_checker.sv
sim/testbench.sv
